@@ rtl/core/rtsp_pkg.sv @@
// Package with the shared constants, register indexes and types of the touch point pipeline.
`timescale 1ns / 1ps
`default_nettype none
package rtsp_pkg;
   localparam int WORD_W     = 16;
   localparam int WORD_SHIFT = 3;
   localparam int RAW_W      = 12;
   localparam int SUM_W      = 14;
   localparam int CNT_W      = 3;
   localparam int DIV_BITS   = 24;
   localparam int PAIR_COUNT = 4;

   localparam logic [12:0] EDGE_LOW   = 13'd50;
   localparam logic [12:0] EDGE_HIGH  = 13'd4046;
   localparam logic [16:0] ADC_SPAN   = 17'd4096;
   localparam logic [15:0] PRESS_MIN  = 16'd30;
   // 65538 / 3: floor(s * RECIP3 / 2^16) equals floor(s / 3) for all s below 2^14.
   localparam logic [14:0] RECIP3     = 15'd21846;

   localparam logic [2:0] REG_RAW_X_LOW  = 3'd0;
   localparam logic [2:0] REG_RAW_X_HIGH = 3'd1;
   localparam logic [2:0] REG_RAW_Y_LOW  = 3'd2;
   localparam logic [2:0] REG_RAW_Y_HIGH = 3'd3;
   localparam logic [2:0] REG_SCREEN_X   = 3'd4;
   localparam logic [2:0] REG_SCREEN_Y   = 3'd5;
   localparam logic [2:0] REG_ORIENT     = 3'd6;
   localparam logic [2:0] REG_PEN_EN     = 3'd7;

   typedef struct packed {
      logic              rej;
      logic [15:0]       press;
      logic [RAW_W-1:0]  avgx;
      logic [RAW_W-1:0]  avgy;
      logic              negx;
      logic              negy;
      logic              zerox;
      logic              zeroy;
      logic [RAW_W-1:0]  dmagx;
      logic [RAW_W-1:0]  dmagy;
   } side_type;

   typedef struct packed {
      logic [RAW_W-1:0]    rem;
      logic [DIV_BITS-1:0] nq;
   } div_type;

   // One restoring step: next numerator bit into the remainder, quotient bit out.
   function automatic div_type div_step(div_type cur, logic [RAW_W-1:0] dmag);
      logic [RAW_W:0] trial;
      logic           ge;
      div_type        nxt;
      trial   = {cur.rem, cur.nq[DIV_BITS-1]};
      ge      = trial >= {1'b0, dmag};
      nxt.rem = ge ? RAW_W'(trial - {1'b0, dmag}) : trial[RAW_W-1:0];
      nxt.nq  = {cur.nq[DIV_BITS-2:0], ge};
      return nxt;
   endfunction
endpackage
`default_nettype wire

@@ rtl/core/rtsp_req_if.sv @@
// Channel interface for touch frames.
`timescale 1ns / 1ps
`default_nettype none
interface rtsp_req_if;
   logic        valid;
   logic        ready;
   logic        pen_level;
   logic [15:0] z1_word;
   logic [15:0] z2_word;
   logic [15:0] x_word_0;
   logic [15:0] y_word_0;
   logic [15:0] x_word_1;
   logic [15:0] y_word_1;
   logic [15:0] x_word_2;
   logic [15:0] y_word_2;
   logic [15:0] x_word_3;
   logic [15:0] y_word_3;
   modport source (output valid, pen_level, z1_word, z2_word, x_word_0, y_word_0,
                   x_word_1, y_word_1, x_word_2, y_word_2, x_word_3, y_word_3,
                   input ready);
   modport sink (input valid, pen_level, z1_word, z2_word, x_word_0, y_word_0,
                 x_word_1, y_word_1, x_word_2, y_word_2, x_word_3, y_word_3,
                 output ready);
endinterface
`default_nettype wire

@@ rtl/core/rtsp_rsp_if.sv @@
// Channel interface for screen points.
`timescale 1ns / 1ps
`default_nettype none
interface rtsp_rsp_if;
   logic        valid;
   logic        ready;
   logic        touched;
   logic [15:0] point_x;
   logic [15:0] point_y;
   logic [15:0] pressure;
   modport source (output valid, touched, point_x, point_y, pressure, input ready);
   modport sink (input valid, touched, point_x, point_y, pressure, output ready);
endinterface
`default_nettype wire

@@ rtl/core/resistive_touch_sample_to_screen_point_top.sv @@
// Touch frame to calibrated screen point: pipelined filter, average, calibration and orientation.
// A frame passes stages 1 to 3, the stage 4 divider load, the 24-stage divider and the output register.
// Throughput is one frame per cycle; the whole pipeline holds while a result waits.
// A rejected frame gives a result with every field 0.
// Reset is synchronous: valid bits clear and the configuration registers take their defaults.
`timescale 1ns / 1ps
`default_nettype none
module resistive_touch_sample_to_screen_point_top
   import rtsp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   rtsp_req_if.sink         req_ch,
   rtsp_rsp_if.source       rsp_ch,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [11:0] csr_wdata
);
   logic [RAW_W-1:0] raw_x_low_ff, raw_x_high_ff, raw_y_low_ff, raw_y_high_ff;
   logic [RAW_W-1:0] scr_x_ff, scr_y_ff;
   logic [2:0]       orient_ff;
   logic             pen_en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_x_low_ff  <= '0;
         raw_x_high_ff <= 12'd4095;
         raw_y_low_ff  <= '0;
         raw_y_high_ff <= 12'd4095;
         scr_x_ff      <= 12'd319;
         scr_y_ff      <= 12'd239;
         orient_ff     <= '0;
         pen_en_ff     <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            REG_RAW_X_LOW:  raw_x_low_ff  <= csr_wdata;
            REG_RAW_X_HIGH: raw_x_high_ff <= csr_wdata;
            REG_RAW_Y_LOW:  raw_y_low_ff  <= csr_wdata;
            REG_RAW_Y_HIGH: raw_y_high_ff <= csr_wdata;
            REG_SCREEN_X:   scr_x_ff      <= csr_wdata;
            REG_SCREEN_Y:   scr_y_ff      <= csr_wdata;
            REG_ORIENT:     orient_ff     <= csr_wdata[2:0];
            REG_PEN_EN:     pen_en_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic out_valid_ff;
   logic adv;
   assign adv          = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   // Stage 1: shift, pressure, pair screening, sums.
   logic [12:0]       xs [PAIR_COUNT];
   logic [12:0]       ys [PAIR_COUNT];
   logic [12:0]       z1s, z2s;
   logic [15:0]       press_in;
   logic [SUM_W-1:0]  sx_in, sy_in;
   logic [CNT_W-1:0]  cnt_in;
   logic              rej1_in;

   assign xs[0] = req_ch.x_word_0[WORD_W-1:WORD_SHIFT];
   assign ys[0] = req_ch.y_word_0[WORD_W-1:WORD_SHIFT];
   assign xs[1] = req_ch.x_word_1[WORD_W-1:WORD_SHIFT];
   assign ys[1] = req_ch.y_word_1[WORD_W-1:WORD_SHIFT];
   assign xs[2] = req_ch.x_word_2[WORD_W-1:WORD_SHIFT];
   assign ys[2] = req_ch.y_word_2[WORD_W-1:WORD_SHIFT];
   assign xs[3] = req_ch.x_word_3[WORD_W-1:WORD_SHIFT];
   assign ys[3] = req_ch.y_word_3[WORD_W-1:WORD_SHIFT];
   assign z1s   = req_ch.z1_word[WORD_W-1:WORD_SHIFT];
   assign z2s   = req_ch.z2_word[WORD_W-1:WORD_SHIFT];

   always_comb begin
      logic pok;
      press_in = 16'({4'b0, z1s} + ADC_SPAN - {4'b0, z2s});
      sx_in    = '0;
      sy_in    = '0;
      cnt_in   = '0;
      for (int i = 0; i < PAIR_COUNT; i++) begin
         pok = xs[i] >= EDGE_LOW && xs[i] <= EDGE_HIGH &&
               ys[i] >= EDGE_LOW && ys[i] <= EDGE_HIGH;
         if (pok) begin
            sx_in  = sx_in + SUM_W'(xs[i][RAW_W-1:0]);
            sy_in  = sy_in + SUM_W'(ys[i][RAW_W-1:0]);
            cnt_in = cnt_in + 3'd1;
         end
      end
      rej1_in = (pen_en_ff && req_ch.pen_level) || press_in < PRESS_MIN;
   end

   logic             v1_ff, rej1_ff;
   logic [15:0]      press1_ff;
   logic [SUM_W-1:0] sx1_ff, sy1_ff;
   logic [CNT_W-1:0] cnt1_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= req_ch.valid;
      if (adv) begin
         rej1_ff   <= rej1_in;
         press1_ff <= press_in;
         sx1_ff    <= sx_in;
         sy1_ff    <= sy_in;
         cnt1_ff   <= cnt_in;
      end
   end

   // Stage 2: average over the valid pairs; fewer than two valid pairs rejects the frame.
   function automatic logic [RAW_W-1:0] avg_of(logic [SUM_W-1:0] s, logic [CNT_W-1:0] c);
      logic [28:0] prod;
      logic [RAW_W-1:0] r;
      prod = {15'b0, s} * {14'b0, RECIP3};
      case (c)
         3'd2:    r = s[RAW_W:1];
         3'd3:    r = prod[27:16];
         3'd4:    r = s[RAW_W+1:2];
         default: r = '0;
      endcase
      return r;
   endfunction

   logic             v2_ff, rej2_ff;
   logic [15:0]      press2_ff;
   logic [RAW_W-1:0] avgx2_ff, avgy2_ff;

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (adv) v2_ff <= v1_ff;
      if (adv) begin
         rej2_ff   <= rej1_ff || cnt1_ff < 3'd2;
         press2_ff <= press1_ff;
         avgx2_ff  <= avg_of(sx1_ff, cnt1_ff);
         avgy2_ff  <= avg_of(sy1_ff, cnt1_ff);
      end
   end

   // Stage 3: calibration numerator and divisor.
   logic               v3_ff, rej3_ff;
   logic [15:0]        press3_ff;
   logic [RAW_W-1:0]   avgx3_ff, avgy3_ff;
   logic signed [26:0] numx3_ff, numy3_ff;
   logic signed [13:0] denx3_ff, deny3_ff;
   logic signed [13:0] dx, dy;
   logic signed [26:0] dxw, dyw, limxw, limyw;

   assign dx = $signed({2'b0, avgx2_ff}) - $signed({2'b0, raw_x_low_ff});
   assign dy = $signed({2'b0, avgy2_ff}) - $signed({2'b0, raw_y_low_ff});

   // Both factors are widened to the product width so no bits are lost.
   assign dxw   = {{13{dx[13]}}, dx};
   assign dyw   = {{13{dy[13]}}, dy};
   assign limxw = {15'b0, scr_x_ff};
   assign limyw = {15'b0, scr_y_ff};

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (adv) v3_ff <= v2_ff;
      if (adv) begin
         rej3_ff   <= rej2_ff;
         press3_ff <= press2_ff;
         avgx3_ff  <= avgx2_ff;
         avgy3_ff  <= avgy2_ff;
         numx3_ff  <= dxw * limxw;
         numy3_ff  <= dyw * limyw;
         denx3_ff  <= $signed({2'b0, raw_x_high_ff}) - $signed({2'b0, raw_x_low_ff});
         deny3_ff  <= $signed({2'b0, raw_y_high_ff}) - $signed({2'b0, raw_y_low_ff});
      end
   end

   // Stage 4 loads the divider with magnitudes; the sign is applied afterward.
   logic [26:0] nabsx, nabsy;
   logic [13:0] dabsx, dabsy;
   assign nabsx = numx3_ff[26] ? 27'(-numx3_ff) : 27'(numx3_ff);
   assign nabsy = numy3_ff[26] ? 27'(-numy3_ff) : 27'(numy3_ff);
   assign dabsx = denx3_ff[13] ? 14'(-denx3_ff) : 14'(denx3_ff);
   assign dabsy = deny3_ff[13] ? 14'(-deny3_ff) : 14'(deny3_ff);

   logic     dv_ff   [DIV_BITS+1];
   side_type side_ff [DIV_BITS+1];
   div_type  divx_ff [DIV_BITS+1];
   div_type  divy_ff [DIV_BITS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DIV_BITS; k++) dv_ff[k] <= 1'b0;
      end else if (adv) begin
         dv_ff[0] <= v3_ff;
         for (int k = 0; k < DIV_BITS; k++) dv_ff[k+1] <= dv_ff[k];
      end
      if (adv) begin
         side_ff[0].rej   <= rej3_ff;
         side_ff[0].press <= press3_ff;
         side_ff[0].avgx  <= avgx3_ff;
         side_ff[0].avgy  <= avgy3_ff;
         side_ff[0].negx  <= numx3_ff[26] ^ denx3_ff[13];
         side_ff[0].negy  <= numy3_ff[26] ^ deny3_ff[13];
         side_ff[0].zerox <= denx3_ff == '0;
         side_ff[0].zeroy <= deny3_ff == '0;
         side_ff[0].dmagx <= dabsx[RAW_W-1:0];
         side_ff[0].dmagy <= dabsy[RAW_W-1:0];
         divx_ff[0].rem   <= '0;
         divx_ff[0].nq    <= nabsx[DIV_BITS-1:0];
         divy_ff[0].rem   <= '0;
         divy_ff[0].nq    <= nabsy[DIV_BITS-1:0];
         for (int k = 0; k < DIV_BITS; k++) begin
            side_ff[k+1] <= side_ff[k];
            divx_ff[k+1] <= div_step(divx_ff[k], side_ff[k].dmagx);
            divy_ff[k+1] <= div_step(divy_ff[k], side_ff[k].dmagy);
         end
      end
   end

   // Final stage: sign, clamp, swap, mirror.
   function automatic logic [RAW_W-1:0] clamp_of(logic zero, logic neg,
                                                 logic [RAW_W-1:0] avg,
                                                 logic [DIV_BITS-1:0] q,
                                                 logic [RAW_W-1:0] lim);
      logic [RAW_W-1:0] r;
      if (zero) r = (avg > lim) ? lim : avg;
      else if (neg) r = '0;
      else r = (q > DIV_BITS'(lim)) ? lim : q[RAW_W-1:0];
      return r;
   endfunction

   side_type         fin;
   logic [RAW_W-1:0] cx, cy;
   logic [15:0]      px_in, py_in, sxp, syp;

   assign fin = side_ff[DIV_BITS];
   assign cx  = clamp_of(fin.zerox, fin.negx, fin.avgx, divx_ff[DIV_BITS].nq, scr_x_ff);
   assign cy  = clamp_of(fin.zeroy, fin.negy, fin.avgy, divy_ff[DIV_BITS].nq, scr_y_ff);
   assign sxp = orient_ff[0] ? 16'(cy) : 16'(cx);
   assign syp = orient_ff[0] ? 16'(cx) : 16'(cy);
   assign px_in = orient_ff[1] ? 16'(16'(scr_x_ff) - sxp) : sxp;
   assign py_in = orient_ff[2] ? 16'(16'(scr_y_ff) - syp) : syp;

   logic        touched_ff;
   logic [15:0] px_ff, py_ff, press_ff;

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (adv) out_valid_ff <= dv_ff[DIV_BITS];
      if (adv) begin
         touched_ff <= !fin.rej;
         px_ff      <= fin.rej ? '0 : px_in;
         py_ff      <= fin.rej ? '0 : py_in;
         press_ff   <= fin.rej ? '0 : fin.press;
      end
   end

   assign rsp_ch.valid    = out_valid_ff;
   assign rsp_ch.touched  = touched_ff;
   assign rsp_ch.point_x  = px_ff;
   assign rsp_ch.point_y  = py_ff;
   assign rsp_ch.pressure = press_ff;

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.touched |->
         rsp_ch.point_x == '0 && rsp_ch.point_y == '0 && rsp_ch.pressure == '0)
      else $error("rejected frame carries nonzero fields");

   a_touch_press: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.touched |-> rsp_ch.pressure >= PRESS_MIN)
      else $error("touch reported below pressure threshold");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready == (!rsp_ch.valid || rsp_ch.ready))
      else $error("input ready disagrees with pipeline advance");

   a_unrotated_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.touched && orient_ff == 3'd0 |->
         rsp_ch.point_x <= 16'(scr_x_ff) && rsp_ch.point_y <= 16'(scr_y_ff))
      else $error("point outside screen limits");
endmodule
`default_nettype wire

@@ tb/sv/rtsp_tb_checker.sv @@
// Checker that watches both channels, predicts each screen point and compares it.
`timescale 1ns / 1ps
module rtsp_tb_checker
   import rtsp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   rtsp_req_if              req_ch,
   rtsp_rsp_if              rsp_ch,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [11:0] csr_wdata,
   output int               fail_count,
   output int               pending_count
);
   typedef struct packed {
      logic        touched;
      logic [15:0] point_x;
      logic [15:0] point_y;
      logic [15:0] pressure;
   } point_type;

   point_type  point_queue[$];
   logic [11:0] cal_x_low, cal_x_high, cal_y_low, cal_y_high, lim_x, lim_y;
   logic [2:0]  orient;
   logic        pen_gate;

   assign pending_count = point_queue.size();

   function automatic int scale_axis(int avg, int lo, int hi, int limit);
      int v;
      v = avg;
      if (hi != lo) v = ((avg - lo) * limit) / (hi - lo);
      if (v < 0) return 0;
      if (v > limit) return limit;
      return v;
   endfunction

   function automatic point_type touch_point(logic pen, logic [15:0] z1w, logic [15:0] z2w,
                                             logic [15:0] xw [4], logic [15:0] yw [4]);
      point_type p;
      logic [15:0] press, px, py, t;
      int sx, sy, cnt, xs, ys;
      p = '0;
      sx = 0; sy = 0; cnt = 0;
      if (pen_gate && pen) return p;
      press = 16'(int'(z1w >> 3) + 4096 - int'(z2w >> 3));
      if (press < 30) return p;
      for (int i = 0; i < 4; i++) begin
         xs = int'(xw[i] >> 3);
         ys = int'(yw[i] >> 3);
         if (xs >= 50 && xs <= 4046 && ys >= 50 && ys <= 4046) begin
            sx += xs; sy += ys; cnt++;
         end
      end
      if (cnt < 2) return p;
      px = 16'(scale_axis(sx / cnt, int'(cal_x_low), int'(cal_x_high), int'(lim_x)));
      py = 16'(scale_axis(sy / cnt, int'(cal_y_low), int'(cal_y_high), int'(lim_y)));
      if (orient[0]) begin
         t = px; px = py; py = t;
      end
      if (orient[1]) px = 16'({4'b0, lim_x} - px);
      if (orient[2]) py = 16'({4'b0, lim_y} - py);
      p.touched = 1'b1;
      p.point_x = px;
      p.point_y = py;
      p.pressure = press;
      return p;
   endfunction

   always @(posedge clock) begin
      logic [15:0] xw [4];
      logic [15:0] yw [4];
      point_type want, got;
      if (reset) begin
         cal_x_low <= 12'd0; cal_x_high <= 12'd4095;
         cal_y_low <= 12'd0; cal_y_high <= 12'd4095;
         lim_x <= 12'd319; lim_y <= 12'd239; orient <= 3'd0; pen_gate <= 1'b0;
         point_queue.delete();
         fail_count <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_RAW_X_LOW:  cal_x_low  <= csr_wdata;
               REG_RAW_X_HIGH: cal_x_high <= csr_wdata;
               REG_RAW_Y_LOW:  cal_y_low  <= csr_wdata;
               REG_RAW_Y_HIGH: cal_y_high <= csr_wdata;
               REG_SCREEN_X:   lim_x      <= csr_wdata;
               REG_SCREEN_Y:   lim_y      <= csr_wdata;
               REG_ORIENT:     orient     <= csr_wdata[2:0];
               REG_PEN_EN:     pen_gate   <= csr_wdata[0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            xw = '{req_ch.x_word_0, req_ch.x_word_1, req_ch.x_word_2, req_ch.x_word_3};
            yw = '{req_ch.y_word_0, req_ch.y_word_1, req_ch.y_word_2, req_ch.y_word_3};
            point_queue.push_back(touch_point(req_ch.pen_level, req_ch.z1_word,
                                              req_ch.z2_word, xw, yw));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.touched, rsp_ch.point_x, rsp_ch.point_y, rsp_ch.pressure};
            if (point_queue.size() == 0) begin
               $display("%0t: unexpected point %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = point_queue.pop_front();
               if (want !== got) begin
                  $display({"%0t: mismatch expected t=%0d x=%0d y=%0d p=%0d,",
                            " got t=%0d x=%0d y=%0d p=%0d"},
                           $time, want.touched, want.point_x, want.point_y, want.pressure,
                           got.touched, got.point_x, got.point_y, got.pressure);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

@@ tb/sv/tb_resistive_touch_sample_to_screen_point_top.sv @@
// Testbench top: clock, reset, register setup, frame stimulus and verdict.
`timescale 1ns / 1ps
module tb_resistive_touch_sample_to_screen_point_top;
   import rtsp_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_we = 0;
   logic [2:0]  csr_index = 0;
   logic [11:0] csr_wdata = 0;
   int          fail_count, pending_count;
   int          send_idle_pct = 0, recv_idle_pct = 0;
   bit          recv_hold = 0;

   rtsp_req_if req_ch();
   rtsp_rsp_if rsp_ch();

   resistive_touch_sample_to_screen_point_top uut (
      .clock, .reset, .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_we, .csr_index, .csr_wdata);

   rtsp_tb_checker chk (
      .clock, .reset, .req_ch, .rsp_ch, .csr_we, .csr_index, .csr_wdata,
      .fail_count, .pending_count);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   initial begin
      #20ms;
      $display("TEST FAILED");
      $finish;
   end

   // Receiver: random stalls, or one long hold-off while frames keep coming.
   always @(negedge clock) begin
      if (recv_hold) rsp_ch.ready <= 0;
      else rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic write_reg(logic [2:0] idx, logic [11:0] val);
      @(negedge clock);
      csr_we <= 1; csr_index <= idx; csr_wdata <= val;
      @(negedge clock);
      csr_we <= 0;
   endtask

   // Raw word whose shifted value is v, with random low bits.
   function automatic logic [15:0] raw_word(int v);
      return 16'((v << 3) | $urandom_range(7));
   endfunction

   // Sample word that is mostly inside the valid window, sometimes near or past its edges.
   function automatic logic [15:0] sample_word();
      case ($urandom_range(9))
         0: return 16'($urandom);
         1: return raw_word($urandom_range(40, 60));
         2: return raw_word($urandom_range(4036, 4056));
         default: return raw_word($urandom_range(50, 4046));
      endcase
   endfunction

   task automatic send_frame(logic pen, logic [15:0] z1, logic [15:0] z2,
                             logic [15:0] s [8]);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 0;
         @(negedge clock);
      end
      req_ch.valid <= 1; req_ch.pen_level <= pen;
      req_ch.z1_word <= z1; req_ch.z2_word <= z2;
      req_ch.x_word_0 <= s[0]; req_ch.y_word_0 <= s[1];
      req_ch.x_word_1 <= s[2]; req_ch.y_word_1 <= s[3];
      req_ch.x_word_2 <= s[4]; req_ch.y_word_2 <= s[5];
      req_ch.x_word_3 <= s[6]; req_ch.y_word_3 <= s[7];
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic random_frame();
      logic [15:0] s [8];
      logic [15:0] z1, z2;
      int press;
      for (int i = 0; i < 8; i++) s[i] = sample_word();
      press = $urandom_range(0, 4095);
      z2 = 16'($urandom);
      // Adding 4096 cancels the pressure formula's offset modulo 8192; the 16-bit result is press or press + 8192.
      case ($urandom_range(9))
         0: z1 = 16'($urandom);
         1: z1 = raw_word((int'(z2 >> 3) + 4096 + $urandom_range(0, 40)) % 8192);
         default: z1 = raw_word((int'(z2 >> 3) + 4096 + press) % 8192);
      endcase
      send_frame($urandom_range(3) == 0, z1, z2, s);
   endtask

   task automatic drain();
      req_ch.valid <= 0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic setup(int xl, int xh, int yl, int yh, int lx, int ly, int o, int pe);
      write_reg(REG_RAW_X_LOW, 12'(xl)); write_reg(REG_RAW_X_HIGH, 12'(xh));
      write_reg(REG_RAW_Y_LOW, 12'(yl)); write_reg(REG_RAW_Y_HIGH, 12'(yh));
      write_reg(REG_SCREEN_X, 12'(lx)); write_reg(REG_SCREEN_Y, 12'(ly));
      write_reg(REG_ORIENT, 12'(o)); write_reg(REG_PEN_EN, 12'(pe));
   endtask

   initial begin
      logic [15:0] s [8];
      int phase;
      req_ch.valid = 0; req_ch.pen_level = 0; req_ch.z1_word = 0; req_ch.z2_word = 0;
      req_ch.x_word_0 = 0; req_ch.y_word_0 = 0; req_ch.x_word_1 = 0; req_ch.y_word_1 = 0;
      req_ch.x_word_2 = 0; req_ch.y_word_2 = 0; req_ch.x_word_3 = 0; req_ch.y_word_3 = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed frames at reset settings, then with the pen gate on, then with all registers zero.
      for (int i = 0; i < 8; i++) s[i] = raw_word(2000);
      send_frame(0, 16'hFFFF, 16'h0000, s);
      send_frame(0, 16'h0000, 16'hFFFF, s);
      send_frame(0, raw_word(29), raw_word(4096), s);
      send_frame(0, raw_word(30), raw_word(4096), s);
      s = '{raw_word(50), raw_word(4046), raw_word(49), raw_word(100),
            raw_word(100), raw_word(4047), raw_word(4046), raw_word(50)};
      send_frame(0, raw_word(500), raw_word(100), s);
      s = '{raw_word(50), raw_word(50), 16'hFFFF, 16'h0000,
            16'h0000, 16'hFFFF, raw_word(4046), raw_word(4046)};
      send_frame(1, raw_word(500), raw_word(100), s);
      s = '{raw_word(1000), raw_word(1000), 0, 0, 0, 0, 0, 0};
      send_frame(0, raw_word(500), raw_word(100), s);
      drain();
      setup(4095, 0, 0, 0, 4095, 4095, 7, 1);
      for (int i = 0; i < 8; i++) s[i] = raw_word(3000);
      send_frame(1, raw_word(500), raw_word(100), s);
      send_frame(0, raw_word(500), raw_word(100), s);
      drain();
      setup(0, 0, 0, 0, 0, 0, 0, 0);
      send_frame(0, raw_word(500), raw_word(100), s);
      drain();

      for (phase = 0; phase < 7; phase++) begin
         setup($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
               $urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
               $urandom_range(7), $urandom_range(1));
         if (phase % 2 == 0)
            setup($urandom_range(0, 300), $urandom_range(3700, 4095),
                  $urandom_range(0, 300), $urandom_range(3700, 4095),
                  $urandom_range(100, 800), $urandom_range(100, 600),
                  $urandom_range(7), $urandom_range(1));
         send_idle_pct = (phase < 2) ? 23 : (phase < 4) ? 50 : 0;
         recv_idle_pct = (phase < 2) ? 50 : (phase < 4) ? 23 : 0;
         if (phase == 5) begin
            fork
               begin
                  recv_hold = 1;
                  repeat (300) @(negedge clock);
                  recv_hold = 0;
               end
            join_none
         end
         repeat (120) random_frame();
         drain();
      end

      if (fail_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end
endmodule
